// ===== hdl/color_contrast_ratio_assert.svh =====
// Assertion macros for the contrast ratio checker.
// Depends on nothing; included by the checker file only.
`ifndef COLOR_CONTRAST_RATIO_ASSERT_SVH
`define COLOR_CONTRAST_RATIO_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CCR_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked after the delay n, disabled while in reset.
`define CCR_ASSERT_DELAY(lbl, ck, rn, ante, n, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##n (cons)) else $error(msg);

`endif

// ===== hdl/ccr_pkg.sv =====
// Shared types, constants and the sRGB linearization table function.
// No dependencies; imported by ccr_lum, the top level and ccr_checker, not by ccr_divider.
package ccr_pkg;

    localparam int LUM_FRAC_BITS_DEF   = 16;
    localparam int RATIO_FRAC_BITS_DEF = 10;

    localparam int COLOR_W     = 24;
    localparam int LIN_W       = 16;
    localparam int LIN_ENTRIES = 256;
    localparam int LUM_Q_W     = 16;
    localparam int RATIO_Q_W   = 15;

    // register stages inside the luminance unit: lookup, weight, sum
    localparam int LUM_STAGES  = 3;

    // Rec. 709 weights in Q0.16; they sum to exactly 1.0
    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    typedef struct packed {
        logic [COLOR_W-1:0] color_a;
        logic               color_a_ok;
        logic [COLOR_W-1:0] color_b;
        logic               color_b_ok;
    } pair_t;

    typedef struct packed {
        logic [RATIO_Q_W-1:0] ratio_q10;
        logic [LUM_Q_W-1:0]   lum_a;
        logic [LUM_Q_W-1:0]   lum_b;
        logic                 ratio_ok;
    } result_t;

    // One entry of the sRGB linearization table in Q0.16. Evaluated at
    // elaboration only: linear segment below the knee, otherwise
    // ((c/255 + 0.055)/1.055)^2.4 in Q0.32 via a bitwise fifth-root search.
    function automatic logic [LIN_W-1:0] lin_entry(input int unsigned c);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] y;
        logic [63:0] cand;
        logic [63:0] c2;
        logic [63:0] c4;
        logic [63:0] c5;
        logic [63:0] lin;
        logic [63:0] r;
        if (64'(c) * 64'd100000 <= 64'd1001640)
        begin
            return LIN_W'((64'(c) * 64'd655360 + 64'd16473) / 64'd32946);
        end
        u = ((64'(c) * 64'd1000 + 64'd14025) << 32) / 64'd269025;
        if (u > 64'hFFFF_FFFF)
        begin
            u = 64'hFFFF_FFFF;
        end
        u2 = (u * u) >> 32;
        y  = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = y | (64'd1 << b);
            c2   = (cand * cand) >> 32;
            c4   = (c2 * c2) >> 32;
            c5   = (c4 * cand) >> 32;
            if (c5 <= u2)
            begin
                y = cand;
            end
        end
        lin = (u2 * y) >> 32;
        r   = (lin + 64'd32768) >> 16;
        if (r > 64'd65535)
        begin
            r = 64'd65535;
        end
        return LIN_W'(r);
    endfunction

endpackage

// ===== hdl/ccr_lum.sv =====
// Relative luminance of one colour: table lookup, weighting, sum and round.
// Depends on ccr_pkg for the linearization table function and weights.
module ccr_lum #(
    parameter int LUM_FRAC_BITS = ccr_pkg::LUM_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic [ccr_pkg::COLOR_W-1:0]       color,
    input  logic                              color_ok,
    output logic [LUM_FRAC_BITS-1:0]          lum,
    output logic                              lum_ok
);
    import ccr_pkg::*;

    localparam int LW = LUM_FRAC_BITS;
    localparam logic [32:0] RND = 33'd1 << (31 - LW);

    logic [LIN_W-1:0] lin_rom [LIN_ENTRIES];

    for (genvar i = 0; i < LIN_ENTRIES; i++)
    begin : g_rom
        localparam logic [LIN_W-1:0] ENTRY = lin_entry(i);
        assign lin_rom[i] = ENTRY;
    end

    logic [LIN_W-1:0] t_r_reg, t_g_reg, t_b_reg;
    logic             ok1_reg;
    logic [31:0]      p_r_reg, p_g_reg, p_b_reg;
    logic             ok2_reg;
    logic [LW-1:0]    lum_reg;
    logic             ok3_reg;

    logic [32:0]      acc_next;
    logic [LW:0]      lum_wide;
    logic [LW-1:0]    lum_next;

    always_comb
    begin
        acc_next = 33'(p_r_reg) + 33'(p_g_reg) + 33'(p_b_reg) + RND;
        lum_wide = (LW+1)'(acc_next >> (32 - LW));
        if (!ok2_reg)
        begin
            lum_next = '0;
        end
        else if (lum_wide[LW])
        begin
            lum_next = '1;
        end
        else
        begin
            lum_next = lum_wide[LW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        t_r_reg <= lin_rom[color[23:16]];
        t_g_reg <= lin_rom[color[15:8]];
        t_b_reg <= lin_rom[color[7:0]];
        ok1_reg <= color_ok;
        p_r_reg <= 32'(W_RED) * 32'(t_r_reg);
        p_g_reg <= 32'(W_GREEN) * 32'(t_g_reg);
        p_b_reg <= 32'(W_BLUE) * 32'(t_b_reg);
        ok2_reg <= ok1_reg;
        lum_reg <= lum_next;
        ok3_reg <= ok2_reg;
    end

    assign lum    = lum_reg;
    assign lum_ok = ok3_reg;

endmodule

// ===== hdl/ccr_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing but its parameters; the tag rides along unchanged.
module ccr_divider #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 17,
    parameter int QW    = 15,
    parameter int TAG_W = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag,
    output logic             out_vld,
    output logic [QW-1:0]    quot,
    output logic [TAG_W-1:0] tag_out
);
    // The caller guarantees num < den * 2^QW, so num >> QW starts below den.
    logic [DEN_W-1:0] rem_reg [QW];
    logic [QW-1:0]    dl_reg  [QW];
    logic [QW-1:0]    q_reg   [QW];
    logic [DEN_W-1:0] den_reg [QW];
    logic [TAG_W-1:0] tag_reg [QW];
    logic [QW-1:0]    vld_reg;

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [QW-1:0]    dl_in;
        logic [QW-1:0]    q_in;
        logic [DEN_W-1:0] den_in;
        logic [TAG_W-1:0] tag_in;
        logic             vld_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (s == 0)
        begin : g_first
            assign rem_in = DEN_W'(num >> QW);
            assign dl_in  = num[QW-1:0];
            assign q_in   = '0;
            assign den_in = den;
            assign tag_in = tag;
            assign vld_in = in_vld;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign dl_in  = dl_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign den_in = den_reg[s-1];
            assign tag_in = tag_reg[s-1];
            assign vld_in = vld_reg[s-1];
        end

        assign trial = {rem_in, dl_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            dl_reg[s]  <= {dl_in[QW-2:0], 1'b0};
            q_reg[s]   <= {q_in[QW-2:0], ge};
            den_reg[s] <= den_in;
            tag_reg[s] <= tag_in;
        end
    end

    assign out_vld = vld_reg[QW-1];
    assign quot    = q_reg[QW-1];
    assign tag_out = tag_reg[QW-1];

endmodule

// ===== hdl/color_contrast_ratio.sv =====
// Top level of the WCAG contrast ratio block: two luminance units,
// the ratio divider and the result register. Depends on ccr_pkg, ccr_lum, ccr_divider.
//
//   channel   handshake        payload              direction
//   pair      start / busy     ccr_pkg::pair_t      in
//   result    done (strobe)    ccr_pkg::result_t    out
//
// One pair enters every cycle; busy stays low. The path runs through three
// luminance stages, one operand stage, one divider stage per quotient bit and
// one output register.
// Reset clears only the valid bits; done is a one-cycle strobe per transfer.
module color_contrast_ratio #(
    parameter int LUM_FRAC_BITS   = ccr_pkg::LUM_FRAC_BITS_DEF,
    parameter int RATIO_FRAC_BITS = ccr_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ccr_pkg::pair_t   pair,
    output logic             done,
    output ccr_pkg::result_t result
);
    import ccr_pkg::*;

    localparam int LW    = LUM_FRAC_BITS;
    localparam int RF    = RATIO_FRAC_BITS;
    localparam int QW    = RF + 5;
    localparam int DEN_W = LW + 1;
    localparam int NUM_W = DEN_W + RF;
    localparam int TAG_W = 2 * LUM_Q_W + 1;
    localparam int DOWN  = (LW > LUM_Q_W) ? LW - LUM_Q_W : 0;
    localparam int UP    = (LW < LUM_Q_W) ? LUM_Q_W - LW : 0;
    localparam int EXT_W = LW + LUM_Q_W;
    localparam logic [DEN_W-1:0] OFF = DEN_W'(((1 << LW) + 10) / 20);
    localparam logic [QW-1:0]    CAP = QW'(21) << RF;

    logic [LUM_STAGES-1:0] vld_reg;

    logic [LW-1:0] lum_a, lum_b;
    logic          lum_a_ok, lum_b_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LUM_STAGES-2:0], start & ~busy};
        end
    end

    ccr_lum #(.LUM_FRAC_BITS(LW)) u_lum_a (
        .clk      (clk),
        .color    (pair.color_a),
        .color_ok (pair.color_a_ok),
        .lum      (lum_a),
        .lum_ok   (lum_a_ok)
    );

    ccr_lum #(.LUM_FRAC_BITS(LW)) u_lum_b (
        .clk      (clk),
        .color    (pair.color_b),
        .color_ok (pair.color_b_ok),
        .lum      (lum_b),
        .lum_ok   (lum_b_ok)
    );

    // operand stage: order the luminances, add the 0.05 offset
    logic [LW-1:0]      hi, lo;
    logic [DEN_W-1:0]   hi_off;
    logic [LUM_Q_W-1:0] lum_a16, lum_b16;

    logic               op_vld_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [TAG_W-1:0]   tag_reg;

    always_comb
    begin
        hi      = (lum_a > lum_b) ? lum_a : lum_b;
        lo      = (lum_a > lum_b) ? lum_b : lum_a;
        hi_off  = DEN_W'(hi) + OFF;
        lum_a16 = LUM_Q_W'((EXT_W'(lum_a) >> DOWN) << UP);
        lum_b16 = LUM_Q_W'((EXT_W'(lum_b) >> DOWN) << UP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_vld_reg <= 1'b0;
        end
        else
        begin
            op_vld_reg <= vld_reg[LUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= {hi_off, {RF{1'b0}}};
        den_reg <= DEN_W'(lo) + OFF;
        tag_reg <= {lum_a16, lum_b16, lum_a_ok & lum_b_ok};
    end

    logic             div_vld;
    logic [QW-1:0]    quot;
    logic [TAG_W-1:0] div_tag;

    ccr_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QW    (QW),
        .TAG_W (TAG_W)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (op_vld_reg),
        .num     (num_reg),
        .den     (den_reg),
        .tag     (tag_reg),
        .out_vld (div_vld),
        .quot    (quot),
        .tag_out (div_tag)
    );

    // output stage: saturate at 21.0, drop the ratio when a colour is malformed
    logic [QW-1:0] ratio_sat;
    result_t       result_next;
    result_t       result_reg;
    logic          done_reg;

    always_comb
    begin
        ratio_sat            = (quot > CAP) ? CAP : quot;
        result_next          = '0;
        result_next.ratio_ok = div_tag[0];
        result_next.lum_b    = div_tag[LUM_Q_W:1];
        result_next.lum_a    = div_tag[TAG_W-1:LUM_Q_W+1];
        if (div_tag[0])
        begin
            result_next.ratio_q10 = RATIO_Q_W'(ratio_sat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/ccr_checker.sv =====
// Port-level checker for the contrast ratio block, bound to the top level.
// Depends on ccr_pkg and the assertion macros in color_contrast_ratio_assert.svh.
`include "color_contrast_ratio_assert.svh"

module ccr_checker #(
    parameter int LUM_FRAC_BITS   = ccr_pkg::LUM_FRAC_BITS_DEF,
    parameter int RATIO_FRAC_BITS = ccr_pkg::RATIO_FRAC_BITS_DEF
) (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input ccr_pkg::pair_t   pair,
    input logic             done,
    input ccr_pkg::result_t result
);
    import ccr_pkg::*;

    // luminance stages, operand stage, one stage per quotient bit, output register
    localparam int LATENCY = LUM_STAGES + 1 + (RATIO_FRAC_BITS + 5) + 1;
    localparam bit RATIO_FITS = (RATIO_FRAC_BITS <= 10);
    localparam bit LUM_EXACT  = (LUM_FRAC_BITS <= 16);
    localparam logic [RATIO_Q_W-1:0] ONE = RATIO_Q_W'(1 << RATIO_FRAC_BITS);
    localparam logic [RATIO_Q_W-1:0] MAX = RATIO_Q_W'(21 << RATIO_FRAC_BITS);

    logic accepted;
    logic both_ok;

    assign accepted = start && !busy;
    assign both_ok  = pair.color_a_ok && pair.color_b_ok;

    `CCR_ASSERT_DELAY(a_latency, clk, rst_n, accepted, LATENCY, done, "result strobe missing after transfer")

    `CCR_ASSERT_DELAY(a_bad_color, clk, rst_n, accepted && !both_ok, LATENCY, !result.ratio_ok, "ratio_ok set for malformed colour")

    `CCR_ASSERT_IMPL(a_zero_ratio, clk, rst_n, done && !result.ratio_ok, result.ratio_q10 == '0, "nonzero ratio without ratio_ok")

    `CCR_ASSERT_IMPL(a_range, clk, rst_n, done && result.ratio_ok, !RATIO_FITS || (result.ratio_q10 >= ONE && result.ratio_q10 <= MAX), "ratio outside 1.0 to 21.0")

    `CCR_ASSERT_IMPL(a_unity, clk, rst_n, done && result.ratio_ok && result.lum_a == result.lum_b, !RATIO_FITS || !LUM_EXACT || result.ratio_q10 == ONE, "equal luminance must give ratio 1.0")

endmodule

bind color_contrast_ratio ccr_checker #(
    .LUM_FRAC_BITS   (LUM_FRAC_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
) u_ccr_checker (.*);

// ===== test/ccr_checker.sv =====
`timescale 1ns / 1ps
// Contrast ratio checker: watches the pair and result channels and predicts each result.
// Depends on ccr_pkg for the payload types; counts mismatches for the testbench top.
module ccr_tb_checker #(
    parameter int LUM_F   = ccr_pkg::LUM_FRAC_BITS_DEF,
    parameter int RATIO_F = ccr_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  ccr_pkg::pair_t   pair,
    input  logic             done,
    input  ccr_pkg::result_t result,
    output int               pending,
    output int               mismatches
);

    // Rec. 709 weights in Q0.16
    localparam logic [63:0] WEIGHT_R = 64'd13933;
    localparam logic [63:0] WEIGHT_G = 64'd46871;
    localparam logic [63:0] WEIGHT_B = 64'd4732;

    logic [15:0]      lin_rom [256];
    ccr_pkg::result_t predicted_results [$];
    ccr_pkg::result_t want;

    function automatic logic [63:0] q32_mul(input logic [63:0] x, input logic [63:0] y);
        return (x * y) >> 32;
    endfunction

    // sRGB code to linear light, Q0.16
    function automatic logic [15:0] srgb_to_linear(input int unsigned code);
        logic [63:0] base;
        logic [63:0] base_sq;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] pow2;
        logic [63:0] pow5;
        logic [63:0] lin;
        if (64'(code) * 64'd100000 <= 64'd1001640)
        begin
            return 16'((64'(code) * 64'd655360 + 64'd16473) / 64'd32946);
        end
        base = ((64'(code) * 64'd1000 + 64'd14025) << 32) / 64'd269025;
        if (base > 64'hFFFF_FFFF)
        begin
            base = 64'hFFFF_FFFF;
        end
        base_sq = q32_mul(base, base);
        // fifth root of base^2, one bit at a time from the top
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            pow2  = q32_mul(trial, trial);
            pow5  = q32_mul(q32_mul(pow2, pow2), trial);
            if (pow5 <= base_sq)
            begin
                root = trial;
            end
        end
        lin = (q32_mul(base_sq, root) + 64'd32768) >> 16;
        return (lin > 64'd65535) ? 16'hFFFF : 16'(lin);
    endfunction

    // relative luminance in Q0.LUM_F, saturated
    function automatic logic [63:0] rel_luminance(input logic [23:0] rgb);
        logic [63:0] acc;
        logic [63:0] lum;
        logic [63:0] full;
        acc = WEIGHT_R * 64'(lin_rom[rgb[23:16]])
            + WEIGHT_G * 64'(lin_rom[rgb[15:8]])
            + WEIGHT_B * 64'(lin_rom[rgb[7:0]]);
        lum  = (acc + (64'd1 << (31 - LUM_F))) >> (32 - LUM_F);
        full = (64'd1 << LUM_F) - 64'd1;
        return (lum > full) ? full : lum;
    endfunction

    function automatic logic [15:0] lum_to_q16(input logic [63:0] lum);
        if (LUM_F > 16)
        begin
            return 16'(lum >> (LUM_F - 16));
        end
        return 16'(lum << (16 - LUM_F));
    endfunction

    function automatic ccr_pkg::result_t contrast_of(input ccr_pkg::pair_t p);
        ccr_pkg::result_t r;
        logic [63:0] la;
        logic [63:0] lb;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] off;
        logic [63:0] quot;
        la   = p.color_a_ok ? rel_luminance(p.color_a) : 64'd0;
        lb   = p.color_b_ok ? rel_luminance(p.color_b) : 64'd0;
        quot = '0;
        if (p.color_a_ok && p.color_b_ok)
        begin
            off  = ((64'd1 << LUM_F) + 64'd10) / 64'd20;
            hi   = (la > lb) ? la : lb;
            lo   = (la > lb) ? lb : la;
            quot = ((hi + off) << RATIO_F) / (lo + off);
            if (quot > (64'd21 << RATIO_F))
            begin
                quot = 64'd21 << RATIO_F;
            end
        end
        r.ratio_q10 = quot[ccr_pkg::RATIO_Q_W-1:0];
        r.lum_a     = lum_to_q16(la);
        r.lum_b     = lum_to_q16(lb);
        r.ratio_ok  = p.color_a_ok && p.color_b_ok;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, exp);
        mismatches++;
    endtask

    initial
    begin
        for (int c = 0; c < 256; c++)
        begin
            lin_rom[8'(c)] = srgb_to_linear(c);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            predicted_results.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (predicted_results.size() == 0)
                begin
                    report("result with nothing pending", 64'(result), 64'd0);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result.ratio_q10 !== want.ratio_q10)
                    begin
                        report("ratio_q10", 64'(result.ratio_q10), 64'(want.ratio_q10));
                    end
                    if (result.lum_a !== want.lum_a)
                    begin
                        report("lum_a", 64'(result.lum_a), 64'(want.lum_a));
                    end
                    if (result.lum_b !== want.lum_b)
                    begin
                        report("lum_b", 64'(result.lum_b), 64'(want.lum_b));
                    end
                    if (result.ratio_ok !== want.ratio_ok)
                    begin
                        report("ratio_ok", 64'(result.ratio_ok), 64'(want.ratio_ok));
                    end
                end
            end
            if (start && !busy)
            begin
                predicted_results = {predicted_results, contrast_of(pair)};
            end
            pending <= predicted_results.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for color_contrast_ratio: drives colour pairs, gives the verdict.
// Depends on ccr_pkg, the block and ccr_tb_checker.
module testbench;

    localparam int RANDOM_PAIRS = 1280;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = ccr_pkg::RATIO_FRAC_BITS_DEF + 20;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    ccr_pkg::pair_t   pair;
    logic             done;
    ccr_pkg::result_t result;
    int               pending;
    int               mismatches;
    int               stall_cycles;
    logic             bursty;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    color_contrast_ratio dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pair   (pair),
        .done   (done),
        .result (result)
    );

    ccr_tb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pair       (pair),
        .done       (done),
        .result     (result),
        .pending    (pending),
        .mismatches (mismatches)
    );

    function automatic ccr_pkg::pair_t mk(input logic [23:0] a, input logic aok,
                                          input logic [23:0] b, input logic bok);
        ccr_pkg::pair_t p;
        p.color_a    = a;
        p.color_a_ok = aok;
        p.color_b    = b;
        p.color_b_ok = bok;
        return p;
    endfunction

    function automatic logic [23:0] near_knee();
        return {8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
                8'($urandom_range(0, 20))};
    endfunction

    function automatic ccr_pkg::pair_t random_pair();
        ccr_pkg::pair_t p;
        int kind;
        kind = $urandom_range(0, 99);
        p = mk(24'($urandom), $urandom_range(0, 9) != 0,
               24'($urandom), $urandom_range(0, 9) != 0);
        if (kind < 12)
        begin
            p.color_a = near_knee();
            p.color_b = near_knee();
        end
        else if (kind < 20)
        begin
            p.color_b = p.color_a;
        end
        else if (kind < 28)
        begin
            p.color_a = {3{8'($urandom)}};
            p.color_b = {3{8'($urandom)}};
        end
        else if (kind < 32)
        begin
            p.color_a = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
        end
        return p;
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (bursty || roll < 60)
        begin
            return 0;
        end
        if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 98)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(16, 60);
    endfunction

    // hold the pair until the transfer; start stays high for a back-to-back pair
    task automatic send_pair(input ccr_pkg::pair_t p);
        start <= 1'b1;
        pair  <= p;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_idle(input ccr_pkg::pair_t p);
        send_pair(p);
        idle(gap_len());
    endtask

    task automatic drain();
        idle(1);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        pair         = '0;
        bursty       = 1'b0;
        stall_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, equal colours, malformed colours, the knee of the curve
        send_idle(mk(24'h000000, 1'b1, 24'hFFFFFF, 1'b1));
        send_idle(mk(24'hFFFFFF, 1'b1, 24'h000000, 1'b1));
        send_idle(mk(24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b1));
        send_idle(mk(24'h000000, 1'b1, 24'h000000, 1'b1));
        send_idle(mk(24'h808080, 1'b1, 24'h808080, 1'b1));
        send_idle(mk(24'hFF0000, 1'b1, 24'h00FF00, 1'b1));
        send_idle(mk(24'h0000FF, 1'b1, 24'hFFFFFF, 1'b1));
        send_idle(mk(24'h0A0A0A, 1'b1, 24'h0B0B0B, 1'b1));
        send_idle(mk(24'h0A0B0A, 1'b1, 24'h010101, 1'b1));
        send_idle(mk(24'h0B0A0B, 1'b1, 24'hF0F0F0, 1'b1));
        send_idle(mk(24'h123456, 1'b0, 24'h654321, 1'b1));
        send_idle(mk(24'h123456, 1'b1, 24'h654321, 1'b0));
        send_idle(mk(24'hFFFFFF, 1'b0, 24'hFFFFFF, 1'b0));
        send_idle(mk(24'h000000, 1'b0, 24'hFFFFFF, 1'b1));
        send_idle(mk(24'hFFFFFF, 1'b1, 24'h000000, 1'b0));
        send_idle(mk(24'h777777, 1'b1, 24'hFFFFFF, 1'b1));
        send_idle(mk(24'h00FF00, 1'b1, 24'h000000, 1'b1));
        send_idle(mk(24'h555555, 1'b1, 24'hAAAAAA, 1'b1));

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i % 150 == 0)
            begin
                bursty = ($urandom_range(0, 2) == 0);
            end
            if (i == RANDOM_PAIRS / 2)
            begin
                drain();
            end
            send_idle(random_pair());
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ccr_pkg.sv
hdl/ccr_lum.sv
hdl/ccr_divider.sv
hdl/color_contrast_ratio.sv
hdl/ccr_checker.sv
test/ccr_checker.sv
test/testbench.sv
